FILE: hw/rtl/pls_pkg.sv
// Shared types and default sizes for the positional list store.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	// Request codes as they arrive on the input stream.
	typedef enum logic [2:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_INSERT     = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_POP_FRONT  = 3'd4,
		REQ_ERASE      = 3'd5,
		REQ_READ_AT    = 3'd6
	} req_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_ERASE  = 2'd2
	} cell_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pls_cell.sv
// One storage cell of the list chain; takes its new value from a neighbor or the input.
`timescale 1ns / 1ps
`default_nettype none

module pls_cell #(
	parameter int DATA_WIDTH = pls_pkg::DEF_DATA_WIDTH,
	parameter int POS_W      = 6,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire pls_pkg::cell_op_t     op,
	input  wire logic [POS_W-1:0]      pos,
	input  wire logic [DATA_WIDTH-1:0] ins_value,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	output logic      [DATA_WIDTH-1:0] data_q
);
	import pls_pkg::*;

	localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

	logic at_pos;
	logic past_pos;

	assign at_pos   = (pos == IDX);
	assign past_pos = (pos < IDX);

	// An insert moves everything past the position up by one; an erase pulls
	// everything at or past the position down by one.
	always_ff @(posedge clk) begin
		case (op)
			CELL_INSERT: begin
				if (at_pos) begin
					data_q <= ins_value;
				end else if (past_pos) begin
					data_q <= left_data;
				end
			end
			CELL_ERASE: begin
				if (at_pos || past_pos) begin
					data_q <= right_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pls_or_tree.sv
// Registered OR-reduction tree that collects the one selected cell value.
`timescale 1ns / 1ps
`default_nettype none

module pls_or_tree #(
	parameter int W     = pls_pkg::DEF_DATA_WIDTH,
	parameter int LEVELS = 6
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] leaf [1 << LEVELS],
	output logic      [W-1:0] root
);
	import pls_pkg::*;

	localparam int L = 1 << LEVELS;

	// Heap-ordered nodes: node n has children 2n and 2n+1, leaves sit at L..2L-1.
	logic [W-1:0] node_q [1:L-1];

	for (genvar n = 1; n < L; n++) begin : g_node
		if (2 * n >= L) begin : g_bottom
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[n] <= leaf[2*n-L] | leaf[2*n+1-L];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (en) begin
					node_q[n] <= node_q[2*n] | node_q[2*n+1];
				end
			end
		end
	end

	assign root = node_q[1];

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_store_core.sv
// Top level of the positional list store: request decode, cell chain and result pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: a result passes through the stage-0 register, the registered OR trees that pick
// the read and back values, and the output register. Throughput: one request per cycle while
// the output is not stalled; the cell chain shifts all entries in the accept cycle.
// Reset clears the element count and all pipeline and output valid bits at once; the stored
// entries are not cleared and are only read below the element count.

module positional_list_store_core #(
	parameter int CAPACITY   = pls_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = pls_pkg::DEF_DATA_WIDTH,
	localparam int POS_W     = $clog2(CAPACITY),
	localparam int CNT_W     = $clog2(CAPACITY + 1),
	localparam int IN_W      = ((POS_W + DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W     = ((2 * DATA_WIDTH + CNT_W + 3 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// Fields from bit 0 up: position, value, zero fill.
	input  wire logic [IN_W-1:0]  s_tdata,
	// Fields from bit 0 up: req_type.
	input  wire logic [2:0]       s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// Fields from bit 0 up: status, read_value, element_count, is_empty, back_value, zero fill.
	output logic      [OUT_W-1:0] m_tdata
);
	import pls_pkg::*;

	localparam int LVL = POS_W;
	localparam int L   = 1 << LVL;

	// Per-request information that travels alongside the reduction trees.
	typedef struct packed {
		status_t          status;
		logic             rd_en;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] count;
	} meta_t;

	// Request fields as they arrive.
	req_t                  req;
	logic [POS_W-1:0]      in_pos;
	logic [DATA_WIDTH-1:0] in_value;
	logic [CNT_W-1:0]      pos_ext;

	// Decode results for the request on the input.
	logic                  accept;
	logic                  adv;
	logic                  full;
	logic                  empty;
	status_t               dec_status;
	cell_op_t              dec_op;
	logic [POS_W-1:0]      dec_pos;
	logic [CNT_W-1:0]      dec_count;
	logic                  dec_rd_en;
	cell_op_t              cell_op;

	logic [CNT_W-1:0]      count_q;

	// The cell chain and the reduction tree leaves.
	logic [DATA_WIDTH-1:0] entry [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_leaf [L];
	logic [DATA_WIDTH-1:0] bk_leaf [L];
	logic [DATA_WIDTH-1:0] rd_root;
	logic [DATA_WIDTH-1:0] bk_root;

	// Side pipeline, stage 0 is the cycle right after the request transaction.
	meta_t                 meta_q [0:LVL];
	logic                  vld_q  [0:LVL];

	// Output register.
	logic                  out_vld_q;
	meta_t                 out_meta_q;
	logic [DATA_WIDTH-1:0] out_rd_q;
	logic [DATA_WIDTH-1:0] out_bk_q;
	logic                  out_empty;

	assign req      = req_t'(s_tuser);
	assign in_pos   = s_tdata[POS_W-1:0];
	assign in_value = s_tdata[POS_W +: DATA_WIDTH];
	assign pos_ext  = CNT_W'(in_pos);

	// The whole pipeline, cells included, moves only when the output register can take
	// a new result. That keeps the leaves of the trees tied to the state they were meant to see.
	assign adv      = !out_vld_q || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	// Request decode. Insert checks the position before the full condition, and a
	// position equal to the count appends. The unused request code changes nothing.
	always_comb begin
		dec_status = ST_OK;
		dec_op     = CELL_HOLD;
		dec_pos    = in_pos;
		dec_count  = count_q;
		dec_rd_en  = 1'b0;
		case (req)
			REQ_PUSH_BACK: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_op    = CELL_INSERT;
					dec_pos   = POS_W'(count_q);
					dec_count = count_q + 1'b1;
				end
			end
			REQ_PUSH_FRONT: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_op    = CELL_INSERT;
					dec_pos   = '0;
					dec_count = count_q + 1'b1;
				end
			end
			REQ_INSERT: begin
				if (pos_ext > count_q) begin
					dec_status = ST_RANGE;
				end else if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_op    = CELL_INSERT;
					dec_count = count_q + 1'b1;
				end
			end
			REQ_POP_BACK: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_count = count_q - 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (empty) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_op    = CELL_ERASE;
					dec_pos   = '0;
					dec_count = count_q - 1'b1;
				end
			end
			REQ_ERASE: begin
				if (pos_ext >= count_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_op    = CELL_ERASE;
					dec_count = count_q - 1'b1;
				end
			end
			REQ_READ_AT: begin
				if (pos_ext >= count_q) begin
					dec_status = ST_RANGE;
				end else begin
					dec_rd_en = 1'b1;
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	assign cell_op = accept ? dec_op : CELL_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= dec_count;
		end
	end

	// The cell chain: every cell sees the broadcast command and both of its neighbors,
	// so an insert or an erase shifts the whole list at once.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_left
			assign left_data = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = '0;
		end else begin : g_right
			assign right_data = entry[i+1];
		end

		pls_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.POS_W      (POS_W),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.pos        (dec_pos),
			.ins_value  (in_value),
			.left_data  (left_data),
			.right_data (right_data),
			.data_q     (entry[i])
		);
	end

	// Leaves: each cell drives its value only when it is the one being read, or when it
	// holds the last element. All others drive zero, so the trees only OR the values.
	for (genvar i = 0; i < L; i++) begin : g_leaf
		if (i < CAPACITY) begin : g_used
			assign rd_leaf[i] = (meta_q[0].rd_en && (meta_q[0].pos == POS_W'(i)))
				? entry[i] : '0;
			assign bk_leaf[i] = (meta_q[0].count == CNT_W'(i + 1)) ? entry[i] : '0;
		end else begin : g_unused
			assign rd_leaf[i] = '0;
			assign bk_leaf[i] = '0;
		end
	end

	pls_or_tree #(
		.W      (DATA_WIDTH),
		.LEVELS (LVL)
	) u_rd_tree (
		.clk  (clk),
		.en   (adv),
		.leaf (rd_leaf),
		.root (rd_root)
	);

	pls_or_tree #(
		.W      (DATA_WIDTH),
		.LEVELS (LVL)
	) u_bk_tree (
		.clk  (clk),
		.en   (adv),
		.leaf (bk_leaf),
		.root (bk_root)
	);

	// Side pipeline, matched to the depth of the trees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LVL; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= accept;
			for (int k = 1; k <= LVL; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q[0] <= '{status: dec_status, rd_en: dec_rd_en, pos: dec_pos,
				count: dec_count};
			for (int k = 1; k <= LVL; k++) begin
				meta_q[k] <= meta_q[k-1];
			end
		end
	end

	// Output register, which holds a finished result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[LVL];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_meta_q <= meta_q[LVL];
			out_rd_q   <= rd_root;
			out_bk_q   <= bk_root;
		end
	end

	assign out_empty = (out_meta_q.count == '0);
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = OUT_W'({out_bk_q, out_empty, out_meta_q.count, out_rd_q,
		out_meta_q.status});

	// The element count never goes past the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count exceeds capacity");

	// A push on a full list leaves the count alone.
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && full && (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT) |=> $stable(count_q))
		else $error("push on a full list changed the count");

	// An empty list reports zero as its last element.
	a_empty_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_empty |-> out_bk_q == '0)
		else $error("empty list reports a nonzero back value");

	// Only a successful read returns a nonzero read value.
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_meta_q.rd_en |-> out_rd_q == '0)
		else $error("read value set without a successful read");

endmodule

`default_nettype wire
